// ----- sv/ipsd_pkg.sv -----
// ---------------------------------------------------------------------------
// ipsd_pkg
// Shared types and constants of the incremental PID speed drive: register
// map, field widths, reset values, the item structs and the duty scaling
// constants.
// ---------------------------------------------------------------------------
package ipsd_pkg;

    // Field widths of the items and registers.
    localparam int SPEED_W = 15;
    localparam int GAIN_W  = 10;
    localparam int SLOPE_W = 16;
    localparam int DUTY_W  = 10;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Register map, one 32-bit word per register.
    typedef enum logic [2:0] {
        REG_TARGET_SPEED  = 3'd0,
        REG_GAIN_P        = 3'd1,
        REG_GAIN_I        = 3'd2,
        REG_GAIN_D        = 3'd3,
        REG_SPEED_CEILING = 3'd4,
        REG_SPEED_FLOOR   = 3'd5,
        REG_DUTY_SLOPE    = 3'd6,
        REG_DUTY_OFFSET   = 3'd7
    } t_reg_idx;

    // Register reset values.
    localparam logic [SPEED_W-1:0] RST_TARGET_SPEED  = 15'd0;
    localparam logic [GAIN_W-1:0]  RST_GAIN_P        = 10'd230;
    localparam logic [GAIN_W-1:0]  RST_GAIN_I        = 10'd26;
    localparam logic [GAIN_W-1:0]  RST_GAIN_D        = 10'd0;
    localparam logic [SPEED_W-1:0] RST_SPEED_CEILING = 15'd1000;
    localparam logic [SPEED_W-1:0] RST_SPEED_FLOOR   = 15'd0;
    localparam logic [SLOPE_W-1:0] RST_DUTY_SLOPE    = 16'd10000;
    localparam logic [DUTY_W-1:0]  RST_DUTY_OFFSET   = 10'd0;

    // Duty mapping: duty = speed * slope / DUTY_SCALE + offset, saturated.
    localparam int DUTY_SCALE = 10000;
    localparam logic [DUTY_W-1:0] DUTY_MAX = 10'd1000;
    localparam int PROD_W = SPEED_W + SLOPE_W;
    // Any product at or above this value saturates the duty on its own.
    localparam logic [PROD_W-1:0] DUTY_SAT_PRODUCT = PROD_W'(1000 * DUTY_SCALE);
    // Products below saturation fit in this many bits.
    localparam int DUTY_QIN_W = 24;
    // Reciprocal of the scale; exact quotients for every input below 2**24.
    localparam int DUTY_RECIP_SHIFT = 37;
    localparam logic [63:0] DUTY_RECIP_WIDE =
        ((64'd1 << DUTY_RECIP_SHIFT) + 64'(DUTY_SCALE) - 64'd1) / 64'(DUTY_SCALE);
    localparam logic [DUTY_QIN_W-1:0] DUTY_RECIP = DUTY_RECIP_WIDE[DUTY_QIN_W-1:0];

    // Configuration register set.
    typedef struct packed {
        logic [SPEED_W-1:0] target_speed;
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_i;
        logic [GAIN_W-1:0]  gain_d;
        logic [SPEED_W-1:0] speed_ceiling;
        logic [SPEED_W-1:0] speed_floor;
        logic [SLOPE_W-1:0] duty_slope;
        logic [DUTY_W-1:0]  duty_offset;
    } t_cfg;

    // One control tick as it arrives.
    typedef struct packed {
        logic [SPEED_W-1:0] measured_speed;
        logic               driver_fault;
        logic               over_temp_warn;
        logic               running;
        logic               pull_direction;
        logic               push_is_clockwise;
    } t_tick;

    // What the tick does to the controller state.
    typedef enum logic [1:0] {
        TICK_FAULT = 2'd0,
        TICK_STOP  = 2'd1,
        TICK_HOLD  = 2'd2,
        TICK_STEP  = 2'd3
    } t_tick_kind;

    // Controller result handed to the duty mapper.
    typedef struct packed {
        logic               updated;
        logic [SPEED_W-1:0] speed;
        logic               off;
        logic               turn_ccw;
    } t_pid_result;

    // Final drive command.
    typedef struct packed {
        logic               updated;
        logic [SPEED_W-1:0] speed;
        logic [DUTY_W-1:0]  duty;
        logic               turn_ccw;
        logic               off;
    } t_drive_cmd;

endpackage

// ----- sv/ipsd_in_if.sv -----
// ---------------------------------------------------------------------------
// ipsd_in_if
// Valid/ready channel that carries one control tick item.
// ---------------------------------------------------------------------------
interface ipsd_in_if;

    logic                       valid;
    logic                       ready;
    logic [ipsd_pkg::SPEED_W-1:0] measured_speed;
    logic                       driver_fault;
    logic                       over_temp_warn;
    logic                       running;
    logic                       pull_direction;
    logic                       push_is_clockwise;

    modport source (
        output valid, measured_speed, driver_fault, over_temp_warn,
               running, pull_direction, push_is_clockwise,
        input  ready
    );

    modport sink (
        input  valid, measured_speed, driver_fault, over_temp_warn,
               running, pull_direction, push_is_clockwise,
        output ready
    );

endinterface

// ----- sv/ipsd_out_if.sv -----
// ---------------------------------------------------------------------------
// ipsd_out_if
// Valid/ready channel that carries one drive command item.
// ---------------------------------------------------------------------------
interface ipsd_out_if;

    logic                         valid;
    logic                         ready;
    logic                         drive_updated;
    logic [ipsd_pkg::SPEED_W-1:0] drive_speed;
    logic [ipsd_pkg::DUTY_W-1:0]  duty_tenths;
    logic                         turn_counterclockwise;
    logic                         drive_off;

    modport source (
        output valid, drive_updated, drive_speed, duty_tenths,
               turn_counterclockwise, drive_off,
        input  ready
    );

    modport sink (
        input  valid, drive_updated, drive_speed, duty_tenths,
               turn_counterclockwise, drive_off,
        output ready
    );

endinterface

// ----- sv/ipsd_pid.sv -----
// ---------------------------------------------------------------------------
// ipsd_pid
// Incremental PID controller pipeline: input register, error history,
// gain products, truncated delta, and the held output with clamping.
// ---------------------------------------------------------------------------
module ipsd_pid #(
    parameter int SPEED_BITS     = 15,
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ipsd_pkg::t_cfg        i_cfg,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  ipsd_pkg::t_tick       i_tick,
    output logic                  o_valid,
    input  logic                  i_ready,
    output ipsd_pkg::t_pid_result o_result
);

    localparam int EW   = SPEED_BITS + 1;
    localparam int D1W  = SPEED_BITS + 2;
    localparam int D2W  = SPEED_BITS + 3;
    localparam int GW   = ipsd_pkg::GAIN_W + 1;
    localparam int PPW  = D1W + GW;
    localparam int PIW  = EW + GW;
    localparam int PDW  = D2W + GW;
    localparam int SUMW = SPEED_BITS + 15;
    localparam int DW   = SUMW - GAIN_FRAC_BITS;
    localparam int OW   = ((DW > ipsd_pkg::SPEED_W + 1) ? DW : ipsd_pkg::SPEED_W + 1) + 1;
    localparam logic [SUMW-1:0] ROUND_BIAS = SUMW'((1 << GAIN_FRAC_BITS) - 1);

    // Stage valid bits and stage readiness.
    logic r0_v, r1_v, r2_v, r3_v, r4_v;
    logic w_rdy0, w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    // Stage 0: input register.
    ipsd_pkg::t_tick r0_tick;

    // Stage 1: error differences.
    ipsd_pkg::t_tick_kind   r1_kind;
    logic                   r1_running;
    logic                   r1_turn;
    logic signed [EW-1:0]   r1_err;
    logic signed [D1W-1:0]  r1_d1;
    logic signed [D2W-1:0]  r1_d2;
    logic signed [EW-1:0]   r_last_error;
    logic signed [EW-1:0]   r_err_prev;

    // Stage 2: gain products.
    ipsd_pkg::t_tick_kind   r2_kind;
    logic                   r2_running;
    logic                   r2_turn;
    logic signed [PPW-1:0]  r2_pp;
    logic signed [PIW-1:0]  r2_pi;
    logic signed [PDW-1:0]  r2_pd;

    // Stage 3: output delta.
    ipsd_pkg::t_tick_kind   r3_kind;
    logic                   r3_running;
    logic                   r3_turn;
    logic signed [DW-1:0]   r3_delta;

    // Stage 4: held output and result.
    logic [SPEED_BITS-1:0]  r_held;
    logic [SPEED_BITS-1:0]  n_held;
    ipsd_pkg::t_pid_result  r4_result;

    logic signed [EW-1:0]   w_err;
    logic signed [D1W-1:0]  w_d1;
    logic signed [D1W-1:0]  w_slope_prev;
    logic signed [D2W-1:0]  w_d2;
    ipsd_pkg::t_tick_kind   w_kind;
    logic signed [SUMW-1:0] w_sum;
    logic signed [SUMW-1:0] w_rounded;
    logic signed [OW-1:0]   w_out;
    logic signed [OW-1:0]   w_ceil;
    logic signed [OW-1:0]   w_floor;
    logic signed [OW-1:0]   w_clamp_hi;
    logic signed [OW-1:0]   w_clamp;

    // A stage takes a new item when it is empty or its item moves on.
    assign w_rdy4  = !r4_v || i_ready;
    assign w_rdy3  = !r3_v || w_rdy4;
    assign w_rdy2  = !r2_v || w_rdy3;
    assign w_rdy1  = !r1_v || w_rdy2;
    assign w_rdy0  = !r0_v || w_rdy1;
    assign o_ready = w_rdy0;
    assign o_valid = r4_v;
    assign o_result = r4_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            if (w_rdy0) begin
                r0_v <= i_valid;
            end
            if (w_rdy1) begin
                r1_v <= r0_v;
            end
            if (w_rdy2) begin
                r2_v <= r1_v;
            end
            if (w_rdy3) begin
                r3_v <= r2_v;
            end
            if (w_rdy4) begin
                r4_v <= r3_v;
            end
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (w_rdy0 && i_valid) begin
            r0_tick <= i_tick;
        end
    end

    // Error against target and its first and second differences.
    assign w_err = $signed({1'b0, i_cfg.target_speed[SPEED_BITS-1:0]})
                 - $signed({1'b0, r0_tick.measured_speed[SPEED_BITS-1:0]});
    assign w_d1         = D1W'(w_err) - D1W'(r_last_error);
    assign w_slope_prev = D1W'(r_last_error) - D1W'(r_err_prev);
    assign w_d2         = D2W'(w_d1) - D2W'(w_slope_prev);

    // Classify the tick.
    always_comb begin
        if (r0_tick.driver_fault || r0_tick.over_temp_warn) begin
            w_kind = ipsd_pkg::TICK_FAULT;
        end else if (!r0_tick.running) begin
            w_kind = ipsd_pkg::TICK_STOP;
        end else if (w_err == '0) begin
            w_kind = ipsd_pkg::TICK_HOLD;
        end else begin
            w_kind = ipsd_pkg::TICK_STEP;
        end
    end

    // Error history: cleared on stop, frozen on fault, shifted otherwise.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_error <= '0;
            r_err_prev   <= '0;
        end else if (w_rdy1 && r0_v) begin
            case (w_kind)
                ipsd_pkg::TICK_FAULT: begin
                    r_last_error <= r_last_error;
                    r_err_prev   <= r_err_prev;
                end
                ipsd_pkg::TICK_STOP: begin
                    r_last_error <= '0;
                    r_err_prev   <= '0;
                end
                default: begin
                    r_last_error <= w_err;
                    r_err_prev   <= r_last_error;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && r0_v) begin
            r1_kind    <= w_kind;
            r1_running <= r0_tick.running;
            r1_turn    <= ~(r0_tick.push_is_clockwise ^ r0_tick.pull_direction);
            r1_err     <= w_err;
            r1_d1      <= w_d1;
            r1_d2      <= w_d2;
        end
    end

    // Gain products; the gains are unsigned and get a zero sign bit.
    always_ff @(posedge i_clk) begin
        if (w_rdy2 && r1_v) begin
            r2_kind    <= r1_kind;
            r2_running <= r1_running;
            r2_turn    <= r1_turn;
            r2_pp <= PPW'($signed({1'b0, i_cfg.gain_p})) * PPW'(r1_d1);
            r2_pi <= PIW'($signed({1'b0, i_cfg.gain_i})) * PIW'(r1_err);
            r2_pd <= PDW'($signed({1'b0, i_cfg.gain_d})) * PDW'(r1_d2);
        end
    end

    // Sum and drop the fraction, truncating toward zero.
    assign w_sum     = SUMW'(r2_pp) + SUMW'(r2_pi) + SUMW'(r2_pd);
    assign w_rounded = w_sum[SUMW-1] ? (w_sum + $signed(ROUND_BIAS)) : w_sum;

    always_ff @(posedge i_clk) begin
        if (w_rdy3 && r2_v) begin
            r3_kind    <= r2_kind;
            r3_running <= r2_running;
            r3_turn    <= r2_turn;
            r3_delta   <= DW'(w_rounded >>> GAIN_FRAC_BITS);
        end
    end

    // New output, clamped to the ceiling first and then to the floor.
    assign w_out   = OW'($signed({1'b0, r_held})) + OW'(r3_delta);
    assign w_ceil  = OW'($signed({1'b0, i_cfg.speed_ceiling}));
    assign w_floor = OW'($signed({1'b0, i_cfg.speed_floor}));
    assign w_clamp_hi = (w_out > w_ceil) ? w_ceil : w_out;
    assign w_clamp    = (w_clamp_hi < w_floor) ? w_floor : w_clamp_hi;

    always_comb begin
        case (r3_kind)
            ipsd_pkg::TICK_STOP: n_held = i_cfg.target_speed[SPEED_BITS-1:0];
            ipsd_pkg::TICK_STEP: n_held = w_clamp[SPEED_BITS-1:0];
            default:             n_held = r_held;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (w_rdy4 && r3_v) begin
            r_held <= n_held;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (w_rdy4 && r3_v) begin
            r4_result.updated  <= (r3_kind == ipsd_pkg::TICK_STEP);
            r4_result.speed    <= ipsd_pkg::SPEED_W'(n_held);
            r4_result.off      <= !r3_running || (n_held == '0);
            r4_result.turn_ccw <= r3_turn;
        end
    end

endmodule

// ----- sv/ipsd_duty.sv -----
// ---------------------------------------------------------------------------
// ipsd_duty
// Maps the controller speed to a PWM duty in 0.1 percent steps: slope
// product, division by the scale through a reciprocal, offset and
// saturation.
// ---------------------------------------------------------------------------
module ipsd_duty (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ipsd_pkg::t_cfg        i_cfg,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  ipsd_pkg::t_pid_result i_result,
    output logic                  o_valid,
    input  logic                  i_ready,
    output ipsd_pkg::t_drive_cmd  o_cmd
);

    localparam int PW = ipsd_pkg::PROD_W;
    localparam int RW = 2 * ipsd_pkg::DUTY_QIN_W;

    logic ra_v, rb_v, rc_v;
    logic w_rdya, w_rdyb, w_rdyc;

    ipsd_pkg::t_pid_result        ra_res;
    logic [PW-1:0]                ra_prod;
    ipsd_pkg::t_pid_result        rb_res;
    logic                         rb_sat;
    logic [ipsd_pkg::DUTY_W-1:0]  rb_quot;
    ipsd_pkg::t_drive_cmd         rc_cmd;

    logic [RW-1:0]                w_recip;
    logic [ipsd_pkg::DUTY_W:0]    w_sum;
    logic [ipsd_pkg::DUTY_W-1:0]  w_duty;

    assign w_rdyc  = !rc_v || i_ready;
    assign w_rdyb  = !rb_v || w_rdyc;
    assign w_rdya  = !ra_v || w_rdyb;
    assign o_ready = w_rdya;
    assign o_valid = rc_v;
    assign o_cmd   = rc_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ra_v <= 1'b0;
            rb_v <= 1'b0;
            rc_v <= 1'b0;
        end else begin
            if (w_rdya) begin
                ra_v <= i_valid;
            end
            if (w_rdyb) begin
                rb_v <= ra_v;
            end
            if (w_rdyc) begin
                rc_v <= rb_v;
            end
        end
    end

    // Speed times slope.
    always_ff @(posedge i_clk) begin
        if (w_rdya && i_valid) begin
            ra_res  <= i_result;
            ra_prod <= PW'(i_result.speed) * PW'(i_cfg.duty_slope);
        end
    end

    // Quotient by the scale; large products saturate on their own.
    assign w_recip = RW'(ra_prod[ipsd_pkg::DUTY_QIN_W-1:0]) * RW'(ipsd_pkg::DUTY_RECIP);

    always_ff @(posedge i_clk) begin
        if (w_rdyb && ra_v) begin
            rb_res  <= ra_res;
            rb_sat  <= (ra_prod >= ipsd_pkg::DUTY_SAT_PRODUCT);
            rb_quot <= w_recip[ipsd_pkg::DUTY_RECIP_SHIFT +: ipsd_pkg::DUTY_W];
        end
    end

    // Offset, saturation, and a zero duty while the drive is off.
    assign w_sum = {1'b0, rb_quot} + {1'b0, i_cfg.duty_offset};

    always_comb begin
        if (rb_res.off) begin
            w_duty = '0;
        end else if (rb_sat || (w_sum > {1'b0, ipsd_pkg::DUTY_MAX})) begin
            w_duty = ipsd_pkg::DUTY_MAX;
        end else begin
            w_duty = w_sum[ipsd_pkg::DUTY_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdyc && rb_v) begin
            rc_cmd.updated  <= rb_res.updated;
            rc_cmd.speed    <= rb_res.speed;
            rc_cmd.duty     <= w_duty;
            rc_cmd.turn_ccw <= rb_res.turn_ccw;
            rc_cmd.off      <= rb_res.off;
        end
    end

endmodule

// ----- sv/incremental_pid_speed_drive_top.sv -----
// ---------------------------------------------------------------------------
// incremental_pid_speed_drive_top
// Incremental PID wire feed speed controller with PWM duty mapping and an
// APB-style register port.
// ---------------------------------------------------------------------------
// Each tick item yields one drive command item; a new tick item can be
// accepted in every cycle unless the output stalls. The controller is a
// five-register pipeline (input, error history, gain products, delta, held
// output) followed by a three-register duty mapper (slope product,
// reciprocal division, offset and saturation). The error history and held
// output loops each close in their own stage, so back-to-back ticks stay
// consistent. Registers lie at byte address 4*i; the user must write them
// only while no item is in flight, which the block does not enforce.
// pready is always high and reads return the stored value.
module incremental_pid_speed_drive_top #(
    parameter int SPEED_BITS     = 15,
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ipsd_pkg::PADDR_W-1:0]  paddr,
    input  logic [ipsd_pkg::PDATA_W-1:0]  pwdata,
    output logic [ipsd_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    ipsd_in_if.sink                       i_in,
    ipsd_out_if.source                    o_out
);

    ipsd_pkg::t_cfg        r_cfg;
    ipsd_pkg::t_reg_idx    w_idx;
    logic                  w_wr;
    ipsd_pkg::t_tick       w_tick;
    logic                  w_pid_valid;
    logic                  w_pid_ready;
    ipsd_pkg::t_pid_result w_pid_result;
    ipsd_pkg::t_drive_cmd  w_cmd;

    // Register port.
    assign pready = 1'b1;
    assign w_idx  = ipsd_pkg::t_reg_idx'(paddr[ipsd_pkg::PADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_speed  <= ipsd_pkg::RST_TARGET_SPEED;
            r_cfg.gain_p        <= ipsd_pkg::RST_GAIN_P;
            r_cfg.gain_i        <= ipsd_pkg::RST_GAIN_I;
            r_cfg.gain_d        <= ipsd_pkg::RST_GAIN_D;
            r_cfg.speed_ceiling <= ipsd_pkg::RST_SPEED_CEILING;
            r_cfg.speed_floor   <= ipsd_pkg::RST_SPEED_FLOOR;
            r_cfg.duty_slope    <= ipsd_pkg::RST_DUTY_SLOPE;
            r_cfg.duty_offset   <= ipsd_pkg::RST_DUTY_OFFSET;
        end else if (w_wr) begin
            case (w_idx)
                ipsd_pkg::REG_TARGET_SPEED:
                    r_cfg.target_speed <= pwdata[ipsd_pkg::SPEED_W-1:0];
                ipsd_pkg::REG_GAIN_P:
                    r_cfg.gain_p <= pwdata[ipsd_pkg::GAIN_W-1:0];
                ipsd_pkg::REG_GAIN_I:
                    r_cfg.gain_i <= pwdata[ipsd_pkg::GAIN_W-1:0];
                ipsd_pkg::REG_GAIN_D:
                    r_cfg.gain_d <= pwdata[ipsd_pkg::GAIN_W-1:0];
                ipsd_pkg::REG_SPEED_CEILING:
                    r_cfg.speed_ceiling <= pwdata[ipsd_pkg::SPEED_W-1:0];
                ipsd_pkg::REG_SPEED_FLOOR:
                    r_cfg.speed_floor <= pwdata[ipsd_pkg::SPEED_W-1:0];
                ipsd_pkg::REG_DUTY_SLOPE:
                    r_cfg.duty_slope <= pwdata[ipsd_pkg::SLOPE_W-1:0];
                ipsd_pkg::REG_DUTY_OFFSET:
                    r_cfg.duty_offset <= pwdata[ipsd_pkg::DUTY_W-1:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // Read back.
    always_comb begin
        case (w_idx)
            ipsd_pkg::REG_TARGET_SPEED:  prdata = ipsd_pkg::PDATA_W'(r_cfg.target_speed);
            ipsd_pkg::REG_GAIN_P:        prdata = ipsd_pkg::PDATA_W'(r_cfg.gain_p);
            ipsd_pkg::REG_GAIN_I:        prdata = ipsd_pkg::PDATA_W'(r_cfg.gain_i);
            ipsd_pkg::REG_GAIN_D:        prdata = ipsd_pkg::PDATA_W'(r_cfg.gain_d);
            ipsd_pkg::REG_SPEED_CEILING: prdata = ipsd_pkg::PDATA_W'(r_cfg.speed_ceiling);
            ipsd_pkg::REG_SPEED_FLOOR:   prdata = ipsd_pkg::PDATA_W'(r_cfg.speed_floor);
            ipsd_pkg::REG_DUTY_SLOPE:    prdata = ipsd_pkg::PDATA_W'(r_cfg.duty_slope);
            ipsd_pkg::REG_DUTY_OFFSET:   prdata = ipsd_pkg::PDATA_W'(r_cfg.duty_offset);
            default:                     prdata = '0;
        endcase
    end

    // Tick item in.
    assign w_tick.measured_speed    = i_in.measured_speed;
    assign w_tick.driver_fault      = i_in.driver_fault;
    assign w_tick.over_temp_warn    = i_in.over_temp_warn;
    assign w_tick.running           = i_in.running;
    assign w_tick.pull_direction    = i_in.pull_direction;
    assign w_tick.push_is_clockwise = i_in.push_is_clockwise;

    ipsd_pid #(
        .SPEED_BITS     (SPEED_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_pid (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_in.valid),
        .o_ready  (i_in.ready),
        .i_tick   (w_tick),
        .o_valid  (w_pid_valid),
        .i_ready  (w_pid_ready),
        .o_result (w_pid_result)
    );

    ipsd_duty u_duty (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (w_pid_valid),
        .o_ready  (w_pid_ready),
        .i_result (w_pid_result),
        .o_valid  (o_out.valid),
        .i_ready  (o_out.ready),
        .o_cmd    (w_cmd)
    );

    // Drive command item out.
    assign o_out.drive_updated         = w_cmd.updated;
    assign o_out.drive_speed           = w_cmd.speed;
    assign o_out.duty_tenths           = w_cmd.duty;
    assign o_out.turn_counterclockwise = w_cmd.turn_ccw;
    assign o_out.drive_off             = w_cmd.off;

    // A stopped drive never carries a duty.
    a_off_no_duty: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.drive_off |-> o_out.duty_tenths == '0
    ) else $error("drive off with nonzero duty");

    // The duty never passes full scale.
    a_duty_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.duty_tenths <= ipsd_pkg::DUTY_MAX
    ) else $error("duty above full scale");

    // An updated command comes from a running tick, so it is off only at zero speed.
    a_update_running: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.drive_updated && o_out.drive_off |-> o_out.drive_speed == '0
    ) else $error("updated command marked off at nonzero speed");

endmodule

// ----- tb/ipsd_drive_checker.sv -----
// ---------------------------------------------------------------------------
// ipsd_drive_checker
// Watches the register port and both item channels of the speed drive.
// Predicts each drive command from its own copy of the registers and the
// controller state, and compares every result field with the oldest
// expected command. Hands the failure count and the number of commands
// still expected to the testbench top.
// ---------------------------------------------------------------------------
module ipsd_drive_checker #(
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic                         i_pready,
    input  logic [ipsd_pkg::PADDR_W-1:0] i_paddr,
    input  logic [ipsd_pkg::PDATA_W-1:0] i_pwdata,
    ipsd_in_if                           i_tick_ch,
    ipsd_out_if                          i_cmd_ch,
    output int                           o_fail_count,
    output int                           o_pending_cmds
);

    timeunit 1ns;
    timeprecision 1ps;

    // Register copy and controller state of the prediction.
    ipsd_pkg::t_cfg               regs;
    logic [ipsd_pkg::SPEED_W-1:0] speed_held;
    int                           err_last;
    int                           err_prev;
    ipsd_pkg::t_drive_cmd         expected_cmds[$];

    initial begin
        o_fail_count   = 0;
        o_pending_cmds = 0;
    end

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string field, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("%0t ns: %s got %0d expected %0d", $time, field, got, want);
        o_fail_count++;
    endtask

    // Applies one tick to the controller state and forms its drive command.
    task automatic advance_drive(input ipsd_pkg::t_tick tk,
                                 output ipsd_pkg::t_drive_cmd cmd);
        ipsd_pkg::t_tick_kind kind;
        int                   err;
        longint               d1;
        longint               d2;
        longint               acc;
        longint               delta;
        longint               nxt;
        longint               duty;
        cmd = '0;
        err = int'(regs.target_speed) - int'(tk.measured_speed);
        if (tk.driver_fault || tk.over_temp_warn) begin
            kind = ipsd_pkg::TICK_FAULT;
        end else if (!tk.running) begin
            kind = ipsd_pkg::TICK_STOP;
        end else if (err == 0) begin
            kind = ipsd_pkg::TICK_HOLD;
        end else begin
            kind = ipsd_pkg::TICK_STEP;
        end

        case (kind)
            ipsd_pkg::TICK_STOP: begin
                err_last   = 0;
                err_prev   = 0;
                speed_held = regs.target_speed;
            end
            ipsd_pkg::TICK_HOLD: begin
                err_prev = err_last;
                err_last = 0;
            end
            ipsd_pkg::TICK_STEP: begin
                // Velocity form: proportional on the error change, integral on
                // the error, derivative on the change of the change.
                d1  = longint'(err) - longint'(err_last);
                d2  = d1 - (longint'(err_last) - longint'(err_prev));
                acc = longint'(regs.gain_p) * d1 + longint'(regs.gain_i) * longint'(err)
                    + longint'(regs.gain_d) * d2;
                // Scale back with truncation toward zero.
                if (acc >= 0) begin
                    delta = acc >>> GAIN_FRAC_BITS;
                end else begin
                    delta = -((-acc) >>> GAIN_FRAC_BITS);
                end
                nxt = longint'(speed_held) + delta;
                // Ceiling first, so a floor above the ceiling wins.
                if (nxt > longint'(regs.speed_ceiling)) nxt = longint'(regs.speed_ceiling);
                if (nxt < longint'(regs.speed_floor)) nxt = longint'(regs.speed_floor);
                speed_held  = nxt[ipsd_pkg::SPEED_W-1:0];
                err_prev    = err_last;
                err_last    = err;
                cmd.updated = 1'b1;
            end
            default: begin
            end
        endcase

        cmd.speed    = speed_held;
        cmd.off      = !tk.running || (speed_held == '0);
        cmd.turn_ccw = ~(tk.push_is_clockwise ^ tk.pull_direction);
        duty = longint'(speed_held) * longint'(regs.duty_slope)
             / longint'(ipsd_pkg::DUTY_SCALE) + longint'(regs.duty_offset);
        if (duty > longint'(ipsd_pkg::DUTY_MAX)) duty = longint'(ipsd_pkg::DUTY_MAX);
        cmd.duty = cmd.off ? '0 : duty[ipsd_pkg::DUTY_W-1:0];
    endtask

    // Register writes, tick prediction and command comparison.
    always @(posedge i_clk) begin
        ipsd_pkg::t_tick      tk;
        ipsd_pkg::t_drive_cmd cmd;
        ipsd_pkg::t_drive_cmd want;
        if (!i_rst_n) begin
            regs.target_speed  = ipsd_pkg::RST_TARGET_SPEED;
            regs.gain_p        = ipsd_pkg::RST_GAIN_P;
            regs.gain_i        = ipsd_pkg::RST_GAIN_I;
            regs.gain_d        = ipsd_pkg::RST_GAIN_D;
            regs.speed_ceiling = ipsd_pkg::RST_SPEED_CEILING;
            regs.speed_floor   = ipsd_pkg::RST_SPEED_FLOOR;
            regs.duty_slope    = ipsd_pkg::RST_DUTY_SLOPE;
            regs.duty_offset   = ipsd_pkg::RST_DUTY_OFFSET;
            speed_held         = '0;
            err_last           = 0;
            err_prev           = 0;
            expected_cmds.delete();
        end else begin
            // Register port write.
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (ipsd_pkg::t_reg_idx'(i_paddr[ipsd_pkg::PADDR_W-1:2]))
                    ipsd_pkg::REG_TARGET_SPEED:
                        regs.target_speed = i_pwdata[ipsd_pkg::SPEED_W-1:0];
                    ipsd_pkg::REG_GAIN_P:
                        regs.gain_p = i_pwdata[ipsd_pkg::GAIN_W-1:0];
                    ipsd_pkg::REG_GAIN_I:
                        regs.gain_i = i_pwdata[ipsd_pkg::GAIN_W-1:0];
                    ipsd_pkg::REG_GAIN_D:
                        regs.gain_d = i_pwdata[ipsd_pkg::GAIN_W-1:0];
                    ipsd_pkg::REG_SPEED_CEILING:
                        regs.speed_ceiling = i_pwdata[ipsd_pkg::SPEED_W-1:0];
                    ipsd_pkg::REG_SPEED_FLOOR:
                        regs.speed_floor = i_pwdata[ipsd_pkg::SPEED_W-1:0];
                    ipsd_pkg::REG_DUTY_SLOPE:
                        regs.duty_slope = i_pwdata[ipsd_pkg::SLOPE_W-1:0];
                    ipsd_pkg::REG_DUTY_OFFSET:
                        regs.duty_offset = i_pwdata[ipsd_pkg::DUTY_W-1:0];
                    default: begin
                    end
                endcase
            end

            // Accepted tick item.
            if (i_tick_ch.valid && i_tick_ch.ready) begin
                tk.measured_speed    = i_tick_ch.measured_speed;
                tk.driver_fault      = i_tick_ch.driver_fault;
                tk.over_temp_warn    = i_tick_ch.over_temp_warn;
                tk.running           = i_tick_ch.running;
                tk.pull_direction    = i_tick_ch.pull_direction;
                tk.push_is_clockwise = i_tick_ch.push_is_clockwise;
                advance_drive(tk, cmd);
                expected_cmds.push_back(cmd);
            end

            // Accepted drive command item.
            if (i_cmd_ch.valid && i_cmd_ch.ready) begin
                if (expected_cmds.size() == 0) begin
                    report_mismatch("unexpected drive command, drive_speed",
                                    16'(i_cmd_ch.drive_speed), 'x);
                end else begin
                    want = expected_cmds.pop_front();
                    if (i_cmd_ch.drive_updated !== want.updated)
                        report_mismatch("drive_updated", 16'(i_cmd_ch.drive_updated),
                                        16'(want.updated));
                    if (i_cmd_ch.drive_speed !== want.speed)
                        report_mismatch("drive_speed", 16'(i_cmd_ch.drive_speed),
                                        16'(want.speed));
                    if (i_cmd_ch.duty_tenths !== want.duty)
                        report_mismatch("duty_tenths", 16'(i_cmd_ch.duty_tenths),
                                        16'(want.duty));
                    if (i_cmd_ch.turn_counterclockwise !== want.turn_ccw)
                        report_mismatch("turn_counterclockwise",
                                        16'(i_cmd_ch.turn_counterclockwise),
                                        16'(want.turn_ccw));
                    if (i_cmd_ch.drive_off !== want.off)
                        report_mismatch("drive_off", 16'(i_cmd_ch.drive_off),
                                        16'(want.off));
                end
            end
        end
        o_pending_cmds = expected_cmds.size();
    end

endmodule

// ----- tb/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// Testbench top of the incremental PID speed drive. Generates clock and
// reset, programs the registers between phases, sends directed and then
// random control ticks with random gaps and output stalls, and gives the
// verdict from the checker's failure count.
// ---------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [ipsd_pkg::PADDR_W-1:0] paddr;
    logic [ipsd_pkg::PDATA_W-1:0] pwdata;
    logic [ipsd_pkg::PDATA_W-1:0] prdata;
    logic                         pready;
    int                           fail_count;
    int                           pending_cmds;
    bit                           no_idle;
    int                           cur_target;

    ipsd_in_if  tick_ch ();
    ipsd_out_if cmd_ch ();

    incremental_pid_speed_drive_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (tick_ch),
        .o_out   (cmd_ch)
    );

    ipsd_drive_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_tick_ch      (tick_ch),
        .i_cmd_ch       (cmd_ch),
        .o_fail_count   (fail_count),
        .o_pending_cmds (pending_cmds)
    );

    // Clock, 20 ns period.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Run limit, far above the slowest correct run.
    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side: random stalls before each drive command item.
    initial begin : cmd_sink
        int stall;
        cmd_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = no_idle ? 0 : int'($urandom_range(0, 17));
            if (stall != 0) begin
                cmd_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            cmd_ch.ready <= 1'b1;
            do @(posedge i_clk); while (cmd_ch.valid !== 1'b1);
            @(negedge i_clk);
        end
    end

    // One register write: setup cycle, then access cycle until pready.
    task automatic write_reg(input ipsd_pkg::t_reg_idx idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= ipsd_pkg::PDATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        @(negedge i_clk);
    endtask

    // Lets the block drain, then writes every register.
    task automatic apply_settings(input int tgt, input int gp, input int gi, input int gd,
                                  input int ceil, input int flr, input int slope,
                                  input int offs);
        tick_ch.valid <= 1'b0;
        while (pending_cmds != 0) @(negedge i_clk);
        write_reg(ipsd_pkg::REG_TARGET_SPEED, tgt);
        write_reg(ipsd_pkg::REG_GAIN_P, gp);
        write_reg(ipsd_pkg::REG_GAIN_I, gi);
        write_reg(ipsd_pkg::REG_GAIN_D, gd);
        write_reg(ipsd_pkg::REG_SPEED_CEILING, ceil);
        write_reg(ipsd_pkg::REG_SPEED_FLOOR, flr);
        write_reg(ipsd_pkg::REG_DUTY_SLOPE, slope);
        write_reg(ipsd_pkg::REG_DUTY_OFFSET, offs);
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        cur_target = tgt;
        @(negedge i_clk);
    endtask

    // Sends one tick item after a random gap.
    task automatic push_tick(input int meas, input bit fault, input bit otw, input bit run,
                             input bit pull, input bit cw);
        int gap;
        gap = no_idle ? 0 : int'($urandom_range(0, 17));
        if (gap != 0) begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        tick_ch.measured_speed    <= meas[ipsd_pkg::SPEED_W-1:0];
        tick_ch.driver_fault      <= fault;
        tick_ch.over_temp_warn    <= otw;
        tick_ch.running           <= run;
        tick_ch.pull_direction    <= pull;
        tick_ch.push_is_clockwise <= cw;
        tick_ch.valid             <= 1'b1;
        do @(posedge i_clk); while (tick_ch.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    // Register value: an extreme now and then, else a typical value.
    function automatic int pick(input int lo, input int hi, input int typical_hi);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return lo;
        if (r == 1) return hi;
        return $urandom_range(lo, typical_hi);
    endfunction

    // Random tick: mostly running ticks around the target, some stops,
    // faults, exact hits and wild measurements.
    task automatic random_tick();
        int       r;
        int       meas;
        bit       pull;
        bit       cw;
        bit [1:0] flags;
        r     = $urandom_range(0, 99);
        pull  = 1'($urandom_range(0, 1));
        cw    = 1'($urandom_range(0, 1));
        flags = 2'($urandom_range(1, 3));
        if (r < 4) begin
            push_tick($urandom_range(0, 32767), flags[1], flags[0],
                      1'($urandom_range(0, 1)), pull, cw);
        end else if (r < 10) begin
            push_tick($urandom_range(0, 32767), 1'b0, 1'b0, 1'b0, pull, cw);
        end else begin
            if (r < 22) begin
                meas = cur_target;
            end else if (r < 75) begin
                meas = cur_target + int'($urandom_range(0, 200)) - 100;
                if (meas < 0) meas = 0;
                if (meas > 32767) meas = 32767;
            end else if (r < 92) begin
                meas = $urandom_range(0, 32767);
            end else begin
                meas = ($urandom_range(0, 1) != 0) ? 32767 : 0;
            end
            push_tick(meas, 1'b0, 1'b0, 1'b1, pull, cw);
        end
    endtask

    // Stimulus and verdict.
    initial begin
        i_rst_n                   = 1'b0;
        psel                      = 1'b0;
        penable                   = 1'b0;
        pwrite                    = 1'b0;
        paddr                     = '0;
        pwdata                    = '0;
        tick_ch.valid             = 1'b0;
        tick_ch.measured_speed    = '0;
        tick_ch.driver_fault      = 1'b0;
        tick_ch.over_temp_warn    = 1'b0;
        tick_ch.running           = 1'b0;
        tick_ch.pull_direction    = 1'b0;
        tick_ch.push_is_clockwise = 1'b0;
        no_idle                   = 1'b0;
        cur_target                = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Normal regulation: stop loads the target, then errors both ways,
        // zero error, clamping at both ends and faults holding everything.
        apply_settings(500, 230, 26, 64, 1000, 0, 10000, 0);
        push_tick(0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        push_tick(0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
        push_tick(500, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1);
        push_tick(400, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
        push_tick(600, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
        push_tick(0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1);
        push_tick(32767, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
        push_tick(100, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
        push_tick(450, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0);
        push_tick(450, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1);
        push_tick(450, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1);
        push_tick(450, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);

        // Largest gains, floor above ceiling and duty saturation.
        apply_settings(32767, 1023, 1023, 1023, 800, 1200, 65535, 1000);
        push_tick(0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
        push_tick(32767, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
        push_tick(0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
        push_tick(32000, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
        push_tick(32767, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1);

        // Zero gains and zero target: the drive stays off.
        apply_settings(0, 0, 0, 0, 32767, 0, 0, 0);
        push_tick(0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        push_tick(0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
        push_tick(5, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1);
        push_tick(32767, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1);

        // Random phases, each with fresh settings.
        for (int ph = 0; ph < 8; ph++) begin
            apply_settings(pick(0, 32767, 32767), pick(0, 1023, 300), pick(0, 1023, 300),
                           pick(0, 1023, 300), pick(0, 32767, 30000), pick(0, 32767, 400),
                           pick(0, 65535, 20000), pick(0, 1000, 200));
            for (int n = 0; n < 75; n++) begin
                if (n % 25 == 0) no_idle = ($urandom_range(0, 3) == 0);
                random_tick();
            end
        end

        // Drain and give the verdict.
        tick_ch.valid <= 1'b0;
        while (pending_cmds != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
